FILE: hdl/bsb_pkg.sv
// ----------------------------------------------------------------------------
// bsb_pkg
// Shared types and constants for the bilinear scaled blit.
// ----------------------------------------------------------------------------
`default_nettype none

package bsb_pkg;

  localparam logic [2:0] REG_SOURCE_LEFT  = 3'd0;
  localparam logic [2:0] REG_SOURCE_TOP   = 3'd1;
  localparam logic [2:0] REG_STEP_X       = 3'd2;
  localparam logic [2:0] REG_STEP_Y       = 3'd3;
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd4;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd5;
  localparam logic [2:0] REG_DEST_LEFT    = 3'd6;
  localparam logic [2:0] REG_DEST_TOP     = 3'd7;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  localparam logic [31:0] PIX_BLACK = 32'hFF00_0000;

  typedef struct packed {
    logic [7:0]  source_left;
    logic [7:0]  source_top;
    logic [15:0] step_x;
    logic [15:0] step_y;
    logic [8:0]  image_width;
    logic [8:0]  image_height;
    logic [7:0]  dest_left;
    logic [7:0]  dest_top;
  } cfg_t;

  typedef struct packed {
    logic       vld;
    logic [8:0] dest_col;
    logic [8:0] dest_row;
  } tag_t;

  typedef enum logic [1:0] {
    NB_STORE = 2'd0,
    NB_BLACK = 2'd1,
    NB_ZERO  = 2'd2
  } nb_src_t;

  // neighbor order: 0 = (x1,y1), 1 = (x1,y2), 2 = (x2,y1), 3 = (x2,y2)
  typedef struct packed {
    logic                 x_odd;
    logic                 y_odd;
    nb_src_t [3:0]        src;
    logic    [3:0][16:0]  wgt;
  } nbr_t;

endpackage

`default_nettype wire

FILE: hdl/bsb_bank.sv
// ----------------------------------------------------------------------------
// bsb_bank
// One pixel bank: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bsb_bank #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [31:0]   rdata_r
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/bsb_coord.sv
// ----------------------------------------------------------------------------
// bsb_coord
// Input stage, Q16.8 source position, bank addressing, clipping and weights.
// ----------------------------------------------------------------------------
`default_nettype none

module bsb_coord #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int AW         = 14
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire bsb_pkg::cfg_t       cfg,
  input  wire logic                in_vld,
  input  wire logic                in_func,
  input  wire logic [7:0]          in_col,
  input  wire logic [7:0]          in_row,
  input  wire logic [31:0]         in_pix,
  output logic      [3:0]          bank_we,
  output logic      [AW-1:0]       bank_waddr,
  output logic      [31:0]         bank_wdata,
  output logic      [3:0][AW-1:0]  bank_raddr,
  output bsb_pkg::tag_t            tag_o,
  output bsb_pkg::nbr_t            nbr_o
);

  localparam int HW = (MAX_WIDTH + 1) / 2;
  localparam int HH = (MAX_HEIGHT + 1) / 2;
  localparam int XW = (HW > 1) ? $clog2(HW) : 1;
  localparam int YW = (HH > 1) ? $clog2(HH) : 1;

  function automatic logic [AW-1:0] baddr(input logic [YW-1:0] r, input logic [XW-1:0] c);
    logic [AW-1:0] base;
    base = AW'(r * HW);
    return base + AW'(c);
  endfunction

  // stage 1: input register
  logic        s1_vld_r;
  logic        s1_func_r;
  logic [7:0]  s1_col_r;
  logic [7:0]  s1_row_r;
  logic [31:0] s1_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
    end
    s1_func_r <= in_func;
    s1_col_r  <= in_col;
    s1_row_r  <= in_row;
    s1_pix_r  <= in_pix;
  end

  // stage 2: source position
  logic        s2_vld_r;
  logic        s2_func_r;
  logic [7:0]  s2_col_r;
  logic [7:0]  s2_row_r;
  logic [31:0] s2_pix_r;
  logic [23:0] sx_r, sx_nxt;
  logic [23:0] sy_r, sy_nxt;
  logic [8:0]  dcol_r, dcol_nxt;
  logic [8:0]  drow_r, drow_nxt;

  always_comb begin
    sx_nxt   = {8'h00, cfg.source_left, 8'h00} + ({16'h0000, s1_col_r} * {8'h00, cfg.step_x});
    sy_nxt   = {8'h00, cfg.source_top, 8'h00} + ({16'h0000, s1_row_r} * {8'h00, cfg.step_y});
    dcol_nxt = {1'b0, cfg.dest_left} + {1'b0, s1_col_r};
    drow_nxt = {1'b0, cfg.dest_top} + {1'b0, s1_row_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_func_r <= s1_func_r;
    s2_col_r  <= s1_col_r;
    s2_row_r  <= s1_row_r;
    s2_pix_r  <= s1_pix_r;
    sx_r      <= sx_nxt;
    sy_r      <= sy_nxt;
    dcol_r    <= dcol_nxt;
    drow_r    <= drow_nxt;
  end

  // stage 2 logic: addresses, clipping, weights
  logic [15:0] x1, y1;
  logic [16:0] x2, y2;
  logic [7:0]  fx, fy;
  logic [8:0]  ifx, ify;
  logic        x1_ok, x2_ok, y1_ok, y2_ok;
  logic [XW-1:0] ec, oc;
  logic [YW-1:0] er, orow;
  logic          ld_ok;
  logic [1:0]    ld_bank;
  bsb_pkg::tag_t tag_nxt;
  bsb_pkg::nbr_t nbr_nxt;

  always_comb begin
    x1    = sx_r[23:8];
    y1    = sy_r[23:8];
    fx    = sx_r[7:0];
    fy    = sy_r[7:0];
    x2    = {1'b0, x1} + 17'd1;
    y2    = {1'b0, y1} + 17'd1;
    ifx   = 9'd256 - {1'b0, fx};
    ify   = 9'd256 - {1'b0, fy};
    x1_ok = ({1'b0, x1} < {8'h00, cfg.image_width}) && (32'(x1) < MAX_WIDTH);
    x2_ok = (x2 < {8'h00, cfg.image_width}) && (32'(x2) < MAX_WIDTH);
    y1_ok = ({1'b0, y1} < {8'h00, cfg.image_height}) && (32'(y1) < MAX_HEIGHT);
    y2_ok = (y2 < {8'h00, cfg.image_height}) && (32'(y2) < MAX_HEIGHT);
    ec    = XW'(x2 >> 1);
    oc    = XW'(x1 >> 1);
    er    = YW'(y2 >> 1);
    orow  = YW'(y1 >> 1);

    for (int b = 0; b < 4; b++) begin
      bank_raddr[b] = baddr(b[1] ? orow : er, b[0] ? oc : ec);
    end

    ld_ok      = s2_vld_r && (s2_func_r == bsb_pkg::FUNC_LOAD) &&
                 (32'(s2_col_r) < MAX_WIDTH) && (32'(s2_row_r) < MAX_HEIGHT);
    ld_bank    = {s2_row_r[0], s2_col_r[0]};
    bank_waddr = baddr(YW'(s2_row_r >> 1), XW'(s2_col_r >> 1));
    bank_wdata = s2_pix_r;
    for (int b = 0; b < 4; b++) begin
      bank_we[b] = ld_ok && (ld_bank == 2'(b));
    end

    tag_nxt.vld      = s2_vld_r && (s2_func_r == bsb_pkg::FUNC_SAMPLE);
    tag_nxt.dest_col = dcol_r;
    tag_nxt.dest_row = drow_r;

    nbr_nxt.x_odd  = x1[0];
    nbr_nxt.y_odd  = y1[0];
    nbr_nxt.src[0] = (x1_ok && y1_ok) ? bsb_pkg::NB_STORE : bsb_pkg::NB_BLACK;
    nbr_nxt.src[1] = (fy == 8'h00) ? bsb_pkg::NB_ZERO :
                     (x1_ok && y2_ok) ? bsb_pkg::NB_STORE : bsb_pkg::NB_BLACK;
    nbr_nxt.src[2] = (fx == 8'h00) ? bsb_pkg::NB_ZERO :
                     (x2_ok && y1_ok) ? bsb_pkg::NB_STORE : bsb_pkg::NB_BLACK;
    nbr_nxt.src[3] = (fx == 8'h00 || fy == 8'h00) ? bsb_pkg::NB_ZERO :
                     (x2_ok && y2_ok) ? bsb_pkg::NB_STORE : bsb_pkg::NB_BLACK;
    nbr_nxt.wgt[0] = {8'h00, ifx} * {8'h00, ify};
    nbr_nxt.wgt[1] = {8'h00, ifx} * {9'h000, fy};
    nbr_nxt.wgt[2] = {9'h000, fx} * {8'h00, ify};
    nbr_nxt.wgt[3] = {9'h000, fx} * {9'h000, fy};
  end

  // stage 3: aligned with bank read data
  bsb_pkg::tag_t tag_r;
  bsb_pkg::nbr_t nbr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.vld <= 1'b0;
    end else begin
      tag_r.vld <= tag_nxt.vld;
    end
    tag_r.dest_col <= tag_nxt.dest_col;
    tag_r.dest_row <= tag_nxt.dest_row;
    nbr_r          <= nbr_nxt;
  end

  assign tag_o = tag_r;
  assign nbr_o = nbr_r;

endmodule

`default_nettype wire

FILE: hdl/bsb_blend.sv
// ----------------------------------------------------------------------------
// bsb_blend
// Neighbor select, weighted products and per-channel sum.
// ----------------------------------------------------------------------------
`default_nettype none

module bsb_blend (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire bsb_pkg::tag_t       tag_i,
  input  wire bsb_pkg::nbr_t       nbr_i,
  input  wire logic [3:0][31:0]    rdata,
  output logic                     out_vld,
  output logic      [8:0]          out_col,
  output logic      [8:0]          out_row,
  output logic      [31:0]         out_pix
);

  logic [3:0][31:0] pix;
  logic [3:0][1:0]  bsel;

  always_comb begin
    bsel[0] = {nbr_i.y_odd, nbr_i.x_odd};
    bsel[1] = {~nbr_i.y_odd, nbr_i.x_odd};
    bsel[2] = {nbr_i.y_odd, ~nbr_i.x_odd};
    bsel[3] = {~nbr_i.y_odd, ~nbr_i.x_odd};
    for (int n = 0; n < 4; n++) begin
      case (nbr_i.src[n])
        bsb_pkg::NB_STORE: pix[n] = rdata[bsel[n]];
        bsb_pkg::NB_BLACK: pix[n] = bsb_pkg::PIX_BLACK;
        default:           pix[n] = 32'h0000_0000;
      endcase
    end
  end

  // stage 4: products
  bsb_pkg::tag_t         s4_tag_r;
  logic [3:0][3:0][24:0] prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_tag_r.vld <= 1'b0;
    end else begin
      s4_tag_r.vld <= tag_i.vld;
    end
    s4_tag_r.dest_col <= tag_i.dest_col;
    s4_tag_r.dest_row <= tag_i.dest_row;
    for (int n = 0; n < 4; n++) begin
      for (int c = 0; c < 4; c++) begin
        prod_r[n][c] <= {17'h00000, pix[n][8*c +: 8]} * {8'h00, nbr_i.wgt[n]};
      end
    end
  end

  // stage 5: sum and output register
  logic [31:0] pix_nxt;
  logic [26:0] acc;

  always_comb begin
    pix_nxt = '0;
    for (int c = 0; c < 4; c++) begin
      acc = {2'b00, prod_r[0][c]} + {2'b00, prod_r[1][c]} +
            {2'b00, prod_r[2][c]} + {2'b00, prod_r[3][c]};
      pix_nxt[8*c +: 8] = acc[23:16];
    end
  end

  logic        vld_r;
  logic [8:0]  col_r;
  logic [8:0]  row_r;
  logic [31:0] pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= s4_tag_r.vld;
    end
    col_r <= s4_tag_r.dest_col;
    row_r <= s4_tag_r.dest_row;
    pix_r <= pix_nxt;
  end

  assign out_vld = vld_r;
  assign out_col = col_r;
  assign out_row = row_r;
  assign out_pix = pix_r;

endmodule

`default_nettype wire

FILE: hdl/bilinear_scaled_blit.sv
// ----------------------------------------------------------------------------
// bilinear_scaled_blit
// Scales an RGBA source image held on chip with bilinear filtering.
//
// Input: an item is taken at every clock edge with start high (busy stays
// low). in_func selects a pixel load into the source store or a sample
// at destination index (in_col, in_row).
// Output: a sample yields one item on the out_ ports, flagged by out_valid
// for one cycle; it passes the input, position, bank read, product and
// output registers in turn. Loads give none.
// Throughput: one item per cycle, loads and samples freely mixed. The
// store is split into four banks by column and row parity, so the 2x2
// neighborhood of a sample is read from the four banks at once.
// Config: cfg_valid/cfg_ready writes register cfg_index with cfg_data;
// cfg_ready is always high. Write only with no item in flight.
// Reset: clears the pipeline and the registers; the source store keeps
// its contents and must be loaded before use. There is no output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_scaled_blit #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_func,
  input  wire logic [7:0]  in_col,
  input  wire logic [7:0]  in_row,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  input  wire logic [7:0]  in_alpha,
  output logic             out_valid,
  output logic      [8:0]  out_dest_col,
  output logic      [8:0]  out_dest_row,
  output logic      [7:0]  out_red,
  output logic      [7:0]  out_green,
  output logic      [7:0]  out_blue,
  output logic      [7:0]  out_alpha,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int HW    = (MAX_WIDTH + 1) / 2;
  localparam int HH    = (MAX_HEIGHT + 1) / 2;
  localparam int DEPTH = HW * HH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  bsb_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source_left  <= 8'd0;
      cfg_r.source_top   <= 8'd0;
      cfg_r.step_x       <= 16'd256;
      cfg_r.step_y       <= 16'd256;
      cfg_r.image_width  <= 9'd256;
      cfg_r.image_height <= 9'd256;
      cfg_r.dest_left    <= 8'd0;
      cfg_r.dest_top     <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bsb_pkg::REG_SOURCE_LEFT:  cfg_r.source_left  <= cfg_data[7:0];
        bsb_pkg::REG_SOURCE_TOP:   cfg_r.source_top   <= cfg_data[7:0];
        bsb_pkg::REG_STEP_X:       cfg_r.step_x       <= cfg_data;
        bsb_pkg::REG_STEP_Y:       cfg_r.step_y       <= cfg_data;
        bsb_pkg::REG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_data[8:0];
        bsb_pkg::REG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_data[8:0];
        bsb_pkg::REG_DEST_LEFT:    cfg_r.dest_left    <= cfg_data[7:0];
        bsb_pkg::REG_DEST_TOP:     cfg_r.dest_top     <= cfg_data[7:0];
        default:                   cfg_r.dest_top     <= cfg_r.dest_top;
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  logic             in_vld;
  logic [3:0]       bank_we;
  logic [AW-1:0]    bank_waddr;
  logic [31:0]      bank_wdata;
  logic [3:0][AW-1:0] bank_raddr;
  logic [3:0][31:0] bank_rdata;
  bsb_pkg::tag_t    tag;
  bsb_pkg::nbr_t    nbr;
  logic [31:0]      res_pix;

  assign in_vld = start && !busy;

  bsb_coord #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_coord (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_vld     (in_vld),
    .in_func    (in_func),
    .in_col     (in_col),
    .in_row     (in_row),
    .in_pix     ({in_alpha, in_blue, in_green, in_red}),
    .bank_we    (bank_we),
    .bank_waddr (bank_waddr),
    .bank_wdata (bank_wdata),
    .bank_raddr (bank_raddr),
    .tag_o      (tag),
    .nbr_o      (nbr)
  );

  for (genvar b = 0; b < 4; b++) begin : g_bank
    bsb_bank #(
      .DEPTH (DEPTH),
      .AW    (AW)
    ) u_bank (
      .clk     (clk),
      .we      (bank_we[b]),
      .waddr   (bank_waddr),
      .wdata   (bank_wdata),
      .raddr   (bank_raddr[b]),
      .rdata_r (bank_rdata[b])
    );
  end

  bsb_blend u_blend (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_i   (tag),
    .nbr_i   (nbr),
    .rdata   (bank_rdata),
    .out_vld (out_valid),
    .out_col (out_dest_col),
    .out_row (out_dest_row),
    .out_pix (res_pix)
  );

  assign out_red   = res_pix[7:0];
  assign out_green = res_pix[15:8];
  assign out_blue  = res_pix[23:16];
  assign out_alpha = res_pix[31:24];

endmodule

`default_nettype wire

FILE: hdl/bsb_chk.sv
// ----------------------------------------------------------------------------
// bsb_chk
// Port-level checks for the bilinear scaled blit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bsb_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        in_func,
  input wire logic        out_valid
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");

  a_sample_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_func == bsb_pkg::FUNC_SAMPLE |-> ##5 out_valid)
    else $error("sample item lost");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_func == bsb_pkg::FUNC_LOAD |-> ##5 !out_valid)
    else $error("load item gave a result");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_func == bsb_pkg::FUNC_SAMPLE, 5))
    else $error("result without sample item");

endmodule

bind bilinear_scaled_blit bsb_chk u_chk (.*);

`default_nettype wire
